FILE: hw/rtl/ffpa_pkg.sv
package ffpa_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int ADDR_BITS   = 16;
    localparam int JOB_BITS    = 8;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;

    localparam logic [ADDR_BITS-1:0] DEFAULT_TOTAL = ADDR_BITS'(640);

    // One partition: start, size, free mark and owner.
    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [ADDR_BITS-1:0] size;
        logic                 free;
        logic [JOB_BITS-1:0]  job;
    } entry_t;

    typedef enum logic [1:0] {
        CC_HOLD,
        CC_FROM_LEFT,
        CC_FROM_RIGHT,
        CC_WRITE
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t cmd;
        logic      tok_start;
        logic      tok_shift;
    } cell_ctl_t;

    // What the scanning token looks for in each cell.
    typedef struct packed {
        logic                 rel_mode;
        logic [JOB_BITS-1:0]  job;
        logic [ADDR_BITS-1:0] req;
    } scan_key_t;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_PROBE   = 2'd2,
        OP_RSVD    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2,
        ST_NOJOB = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MERGE_NEXT,
        S_MERGE_PREV,
        S_DONE
    } state_t;

endpackage

FILE: hw/rtl/ffpa_cell.sv
module ffpa_cell
    import ffpa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  entry_t    init_entry,
    input  logic      tok_first,
    input  cell_ctl_t ctl,
    input  entry_t    wdata,
    input  entry_t    left_entry,
    input  entry_t    right_entry,
    input  logic      left_tok,
    input  logic      valid,
    input  scan_key_t key,
    output entry_t    entry_q,
    output logic      tok_q,
    output logic      hit,
    output entry_t    hit_entry
);

    entry_t entry_reg, entry_next;
    logic   tok_reg, tok_next;
    logic   match;

    always_comb begin
        case (ctl.cmd)
            CC_FROM_LEFT:  entry_next = left_entry;
            CC_FROM_RIGHT: entry_next = right_entry;
            CC_WRITE:      entry_next = wdata;
            default:       entry_next = entry_reg;
        endcase
        if (ctl.tok_start) begin
            tok_next = tok_first;
        end else if (ctl.tok_shift) begin
            tok_next = left_tok;
        end else begin
            tok_next = tok_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= init_entry;
            tok_reg   <= 1'b0;
        end else begin
            entry_reg <= entry_next;
            tok_reg   <= tok_next;
        end
    end

    // A release looks for an owned entry of the job, the others for a free
    // entry that is large enough.
    assign match = key.rel_mode ? (!entry_reg.free && entry_reg.job == key.job)
                                : (entry_reg.free && entry_reg.size >= key.req);

    assign hit       = tok_reg & valid & match;
    assign hit_entry = hit ? entry_reg : '0;
    assign entry_q   = entry_reg;
    assign tok_q     = tok_reg;

endmodule

FILE: hw/rtl/first_fit_partition_allocator_core.sv
// Channel | Direction | Words
// s_      | in        | one request: operation, job id, requested size
// m_      | out       | one response per request: status, block start, block size
// cfg_    | in        | total memory size; reinitializes the partition table
//
// A response reaches the output register after the scan state, the merge-next and
// merge-prev states for a successful release, and the done state; the scan walks the
// entries (at most 16) up to a hit, the token in the chain of cells moving one cell per
// cycle. Idle comes back as the response is registered; only then is a request taken.
// Reset (synchronous, active low) leaves one free partition of 640 units.
// A finished response waits in the output register; the next request is taken
// while it waits, and a second finished response holds until the first leaves.
module first_fit_partition_allocator_core
    import ffpa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [1:0] operation, [9:2] job_id, [25:10] request_size
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [1:0] status, [17:2] block_start, [33:18] block_size
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    state_t state_reg, state_next;

    logic [1:0]           op_reg, op_next;
    logic [JOB_BITS-1:0]  job_reg, job_next;
    logic [ADDR_BITS-1:0] req_reg, req_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;

    logic [1:0]           res_status_reg, res_status_next;
    logic [ADDR_BITS-1:0] res_start_reg, res_start_next;
    logic [ADDR_BITS-1:0] res_size_reg, res_size_next;

    logic                 m_valid_reg, m_valid_next;
    logic [1:0]           m_status_reg, m_status_next;
    logic [ADDR_BITS-1:0] m_start_reg, m_start_next;
    logic [ADDR_BITS-1:0] m_size_reg, m_size_next;

    cell_ctl_t ctl     [MAX_ENTRIES];
    entry_t    wdata   [MAX_ENTRIES];
    entry_t    cell_q  [MAX_ENTRIES];
    entry_t    hit_e_c [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] tok_c, hit_c;

    scan_key_t key;
    entry_t    hit_e;
    logic      hit_any;
    logic      s_acc, cfg_acc, out_free;
    logic      zero_req, alloc_fits_exact, table_full, at_end;
    logic      next_free, prev_free;
    logic [CNT_W-1:0] idx_p1, idx_m1;

    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign out_free  = !m_valid_reg || m_tready;

    assign key.rel_mode = (op_t'(op_reg) == OP_RELEASE);
    assign key.job      = job_reg;
    assign key.req      = req_reg;

    // ---------------------------------------------------------------- cells
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        entry_t init_e;
        always_comb begin
            init_e = '0;
            if (g == 0) begin
                init_e.size = DEFAULT_TOTAL;
                init_e.free = 1'b1;
            end
        end

        ffpa_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .init_entry  (init_e),
            .tok_first   (g == 0),
            .ctl         (ctl[g]),
            .wdata       (wdata[g]),
            .left_entry  ((g == 0) ? entry_t'('0) : cell_q[(g == 0) ? 0 : g - 1]),
            .right_entry ((g == MAX_ENTRIES - 1) ? entry_t'('0)
                                : cell_q[(g == MAX_ENTRIES - 1) ? g : g + 1]),
            .left_tok    ((g == 0) ? 1'b0 : tok_c[(g == 0) ? 0 : g - 1]),
            .valid       (CNT_W'(g) < cnt_reg),
            .key         (key),
            .entry_q     (cell_q[g]),
            .tok_q       (tok_c[g]),
            .hit         (hit_c[g]),
            .hit_entry   (hit_e_c[g])
        );
    end

    // At most one cell holds the token, so the hit entry is a plain OR.
    always_comb begin
        hit_e = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            hit_e = hit_e | hit_e_c[i];
        end
    end

    assign hit_any          = |hit_c;
    assign zero_req         = (req_reg == '0);
    assign alloc_fits_exact = (hit_e.size == req_reg);
    assign table_full       = (cnt_reg == CNT_W'(MAX_ENTRIES));
    assign at_end           = (idx_reg == cnt_reg);
    assign idx_p1           = idx_reg + CNT_W'(1);
    assign idx_m1           = idx_reg - CNT_W'(1);
    assign next_free        = (idx_p1 < cnt_reg) && cell_q[idx_p1[IDX_W-1:0]].free;
    assign prev_free        = (idx_reg != '0) && cell_q[idx_m1[IDX_W-1:0]].free;

    // ---------------------------------------------------------- next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    if (op_t'(s_tdata[1:0]) == OP_RSVD ||
                        (op_t'(s_tdata[1:0]) != OP_RELEASE && s_tdata[25:10] == '0)) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (hit_any) begin
                    state_next = (op_t'(op_reg) == OP_RELEASE) ? S_MERGE_NEXT : S_DONE;
                end else if (at_end) begin
                    state_next = S_DONE;
                end
            end
            S_MERGE_NEXT: state_next = S_MERGE_PREV;
            S_MERGE_PREV: state_next = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------ datapath/control
    always_comb begin
        op_next         = op_reg;
        job_next        = job_reg;
        req_next        = req_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        res_size_next   = res_size_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_start_next    = m_start_reg;
        m_size_next     = m_size_reg;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            ctl[i]   = '{cmd: CC_HOLD, tok_start: 1'b0, tok_shift: 1'b0};
            wdata[i] = '0;
        end

        case (state_reg)
            S_IDLE: begin
                if (cfg_acc) begin
                    // Rebuild the table as one free partition.
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        ctl[i].cmd = CC_WRITE;
                    end
                    wdata[0].size = cfg_data;
                    wdata[0].free = 1'b1;
                    cnt_next      = CNT_W'(1);
                end else if (s_acc) begin
                    op_next         = s_tdata[1:0];
                    job_next        = s_tdata[9:2];
                    req_next        = s_tdata[25:10];
                    idx_next        = '0;
                    res_status_next = ST_NOFIT;
                    res_start_next  = '0;
                    res_size_next   = '0;
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        ctl[i].tok_start = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (hit_any) begin
                    case (op_t'(op_reg))
                        OP_ALLOC: begin
                            if (alloc_fits_exact) begin
                                ctl[idx_reg[IDX_W-1:0]].cmd   = CC_WRITE;
                                wdata[idx_reg[IDX_W-1:0]]       = hit_e;
                                wdata[idx_reg[IDX_W-1:0]].free  = 1'b0;
                                wdata[idx_reg[IDX_W-1:0]].job   = job_reg;
                                res_status_next = ST_OK;
                                res_start_next  = hit_e.start;
                                res_size_next   = req_reg;
                            end else if (table_full) begin
                                res_status_next = ST_FULL;
                            end else begin
                                // Split: owned front part, free remainder,
                                // everything behind moves one cell right.
                                for (int i = 0; i < MAX_ENTRIES; i++) begin
                                    if (CNT_W'(i) == idx_reg) begin
                                        ctl[i].cmd     = CC_WRITE;
                                        wdata[i].start = hit_e.start;
                                        wdata[i].size  = req_reg;
                                        wdata[i].free  = 1'b0;
                                        wdata[i].job   = job_reg;
                                    end else if (CNT_W'(i) == idx_p1) begin
                                        ctl[i].cmd     = CC_WRITE;
                                        wdata[i].start = hit_e.start + req_reg;
                                        wdata[i].size  = hit_e.size - req_reg;
                                        wdata[i].free  = 1'b1;
                                        wdata[i].job   = '0;
                                    end else if (CNT_W'(i) > idx_p1) begin
                                        ctl[i].cmd = CC_FROM_LEFT;
                                    end
                                end
                                cnt_next        = cnt_reg + CNT_W'(1);
                                res_status_next = ST_OK;
                                res_start_next  = hit_e.start;
                                res_size_next   = req_reg;
                            end
                        end
                        OP_RELEASE: begin
                            ctl[idx_reg[IDX_W-1:0]].cmd  = CC_WRITE;
                            wdata[idx_reg[IDX_W-1:0]]      = hit_e;
                            wdata[idx_reg[IDX_W-1:0]].free = 1'b1;
                            wdata[idx_reg[IDX_W-1:0]].job  = '0;
                            res_status_next = ST_OK;
                            res_start_next  = hit_e.start;
                            res_size_next   = hit_e.size;
                        end
                        default: begin
                            res_status_next = ST_OK;
                        end
                    endcase
                end else if (at_end) begin
                    res_status_next = (op_t'(op_reg) == OP_RELEASE) ? ST_NOJOB : ST_NOFIT;
                end else begin
                    idx_next = idx_p1;
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        ctl[i].tok_shift = 1'b1;
                    end
                end
            end
            S_MERGE_NEXT: begin
                // Absorb a free right neighbor into the released entry.
                if (next_free) begin
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        if (CNT_W'(i) == idx_reg) begin
                            ctl[i].cmd    = CC_WRITE;
                            wdata[i]      = cell_q[i];
                            wdata[i].size = cell_q[i].size + cell_q[idx_p1[IDX_W-1:0]].size;
                        end else if (CNT_W'(i) > idx_reg) begin
                            ctl[i].cmd = CC_FROM_RIGHT;
                        end
                    end
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            S_MERGE_PREV: begin
                // Fold the released entry into a free left neighbor.
                if (prev_free) begin
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        if (CNT_W'(i) == idx_m1) begin
                            ctl[i].cmd    = CC_WRITE;
                            wdata[i]      = cell_q[i];
                            wdata[i].size = cell_q[i].size + cell_q[idx_reg[IDX_W-1:0]].size;
                        end else if (CNT_W'(i) >= idx_reg) begin
                            ctl[i].cmd = CC_FROM_RIGHT;
                        end
                    end
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_start_next  = res_start_reg;
                    m_size_next   = res_size_reg;
                end
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= CNT_W'(1);
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        job_reg        <= job_next;
        req_reg        <= req_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        res_size_reg   <= res_size_next;
        m_status_reg   <= m_status_next;
        m_start_reg    <= m_start_next;
        m_size_reg     <= m_size_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_size_reg, m_start_reg, m_status_reg};

`ifndef SYNTHESIS
    // The scan token sits in at most one cell.
    a_tok_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_c))
        else $error("scan token in more than one cell");

    // The table never becomes empty and never overflows.
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg >= CNT_W'(1) && cnt_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count out of range");

    // An accepted request keeps the input closed in the next cycle.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in work");

    // A split only happens with room for the remainder.
    a_split_room: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN && cnt_next > cnt_reg |-> !table_full)
        else $error("split with a full table");
`endif

endmodule

FILE: tb/sv/tb_top.sv
module tb_top
    import ffpa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // One request word as the block sees it on s_tdata.
    typedef struct {
        op_t              op;
        logic [7:0]       job;
        logic [15:0]      req;
    } request_t;

    // One response word as it leaves on m_tdata.
    typedef struct {
        status_t          status;
        logic [15:0]      bstart;
        logic [15:0]      bsize;
    } response_t;

    typedef struct {
        logic [15:0] start;
        logic [15:0] size;
        logic        free;
        logic [7:0]  job;
    } part_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    first_fit_partition_allocator_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // The testbench keeps its own copy of the partition table. It is updated
    // as each request word is accepted, so expected responses are queued in
    // order of acceptance, which is also the order the block answers in.
    part_t       parts[MAX_ENTRIES];
    int unsigned part_count;
    logic [15:0] managed_size;

    response_t   pending_responses[$];
    int unsigned error_count;
    int unsigned response_count;
    longint unsigned cycle_count;

    // Random idling control. When quiet_mode is set neither side idles,
    // and hold_off_cycles makes the receiver stall for a long stretch.
    bit          quiet_mode;
    int unsigned hold_off_cycles;

    // Counters for the summary lines.
    int unsigned op_seen[4];
    int unsigned status_seen[4];

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Rebuilds the table as one free partition covering the managed memory.
    function automatic void clear_partitions(input logic [15:0] total);
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            parts[k] = '{16'd0, 16'd0, 1'b0, 8'd0};
        end
        managed_size = total;
        parts[0] = '{16'd0, total, 1'b1, 8'd0};
        part_count = 1;
    endfunction

    // Joins every run of neighbouring free partitions into one.
    function automatic void coalesce_free();
        int unsigned idx;
        idx = 0;
        while (idx + 1 < part_count) begin
            if (parts[idx].free && parts[idx + 1].free) begin
                parts[idx].size = parts[idx].size + parts[idx + 1].size;
                for (int k = idx + 1; k + 1 < part_count; k++) begin
                    parts[k] = parts[k + 1];
                end
                part_count--;
                parts[part_count] = '{16'd0, 16'd0, 1'b0, 8'd0};
            end else begin
                idx++;
            end
        end
    endfunction

    // Computes the response to one request and applies its effect on the table.
    function automatic response_t allocate_or_release(input request_t rq);
        response_t rsp;
        rsp = '{ST_NOFIT, 16'd0, 16'd0};
        case (rq.op)
            OP_ALLOC: begin
                if (rq.req != 16'd0) begin
                    for (int i = 0; i < part_count; i++) begin
                        if (parts[i].free && parts[i].size >= rq.req) begin
                            if (parts[i].size == rq.req) begin
                                parts[i].free = 1'b0;
                                parts[i].job  = rq.job;
                                rsp = '{ST_OK, parts[i].start, rq.req};
                            end else if (part_count >= MAX_ENTRIES) begin
                                rsp.status = ST_FULL;
                            end else begin
                                for (int k = part_count; k > i; k--) begin
                                    parts[k] = parts[k - 1];
                                end
                                part_count++;
                                parts[i].size = rq.req;
                                parts[i].free = 1'b0;
                                parts[i].job  = rq.job;
                                parts[i + 1].start = parts[i + 1].start + rq.req;
                                parts[i + 1].size  = parts[i + 1].size - rq.req;
                                rsp = '{ST_OK, parts[i].start, rq.req};
                            end
                            break;
                        end
                    end
                end
            end
            OP_RELEASE: begin
                rsp.status = ST_NOJOB;
                for (int i = 0; i < part_count; i++) begin
                    if (!parts[i].free && parts[i].job == rq.job) begin
                        parts[i].free = 1'b1;
                        parts[i].job  = 8'd0;
                        rsp = '{ST_OK, parts[i].start, parts[i].size};
                        coalesce_free();
                        break;
                    end
                end
            end
            OP_PROBE: begin
                if (rq.req != 16'd0) begin
                    for (int i = 0; i < part_count; i++) begin
                        if (parts[i].free && parts[i].size >= rq.req) begin
                            rsp.status = ST_OK;
                            break;
                        end
                    end
                end
            end
            default: begin
                // The reserved operation leaves the table alone and reports no fit.
            end
        endcase
        return rsp;
    endfunction

    // Sends one request word and queues its expected response on acceptance.
    // The valid line stays up after acceptance; the next call either drives
    // a new word or drops it to idle, in that same time step.
    task automatic send_request(input op_t op, input logic [7:0] job,
                                input logic [15:0] req);
        request_t rq;
        rq = '{op, job, req};
        while (!quiet_mode && $urandom_range(99) < 8) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, req, job, op};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        pending_responses.push_back(allocate_or_release(rq));
        op_seen[op]++;
    endtask

    // Waits until every response is back, lets the block settle, then writes
    // the total-size register. Writes happen only while the block is idle.
    task automatic write_total_size(input logic [15:0] total);
        s_tvalid <= 1'b0;
        while (pending_responses.size() != 0) begin
            @(posedge aclk);
        end
        repeat (24) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= total;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        clear_partitions(total);
    endtask

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_off_cycles != 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet_mode || ($urandom_range(99) >= 8);
        end
    end

    // Compares each accepted response word with the oldest expectation.
    always @(posedge aclk) begin
        response_t got;
        response_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = status_t'(m_tdata[1:0]);
            got.bstart = m_tdata[17:2];
            got.bsize  = m_tdata[33:18];
            response_count++;
            if (pending_responses.size() == 0) begin
                $display("%0t: unexpected response status=%0d start=%0d size=%0d",
                         $time, got.status, got.bstart, got.bsize);
                error_count++;
            end else begin
                want = pending_responses.pop_front();
                status_seen[got.status]++;
                if (got.status != want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                    error_count++;
                end
                if (got.bstart != want.bstart) begin
                    $display("%0t: block_start expected %0d actual %0d",
                             $time, want.bstart, got.bstart);
                    error_count++;
                end
                if (got.bsize != want.bsize) begin
                    $display("%0t: block_size expected %0d actual %0d",
                             $time, want.bsize, got.bsize);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: the slowest correct run is well under this bound.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Extremes of each field, every operation and the named corner cases.
    task automatic test_directed();
        send_request(OP_ALLOC, 8'd1, 16'd0);        // zero-size allocate
        send_request(OP_PROBE, 8'd0, 16'd0);        // zero-size probe
        send_request(OP_PROBE, 8'hFF, 16'hFFFF);    // too large to fit
        send_request(OP_ALLOC, 8'hFF, 16'hFFFF);
        send_request(OP_RSVD, 8'hAA, 16'h5555);     // reserved operation
        send_request(OP_RELEASE, 8'd7, 16'd0);      // job owns nothing
        send_request(OP_ALLOC, 8'd3, 16'd100);
        send_request(OP_ALLOC, 8'd3, 16'd50);       // job owns two blocks
        send_request(OP_ALLOC, 8'd4, 16'd490);      // exact fit of the rest
        send_request(OP_PROBE, 8'd0, 16'd1);
        send_request(OP_RELEASE, 8'd3, 16'hFFFF);   // frees only the first
        send_request(OP_RELEASE, 8'd3, 16'd0);      // merges with the first
        send_request(OP_PROBE, 8'd0, 16'd150);
        send_request(OP_RELEASE, 8'd4, 16'd0);
        send_request(OP_ALLOC, 8'd0, 16'd640);
        send_request(OP_RELEASE, 8'd0, 16'd0);
        // Fill the table with small splits until a split finds it full.
        for (int k = 0; k < 17; k++) begin
            send_request(OP_ALLOC, 8'(k + 10), 16'd1);
        end
        send_request(OP_ALLOC, 8'd99, 16'd1);
    endtask

    // Extremes of the register: zero size, one unit and the largest size.
    task automatic test_register_extremes();
        write_total_size(16'd0);
        send_request(OP_ALLOC, 8'd1, 16'd1);
        send_request(OP_PROBE, 8'd1, 16'd1);
        write_total_size(16'd1);
        send_request(OP_ALLOC, 8'd2, 16'd1);
        send_request(OP_RELEASE, 8'd2, 16'd0);
        write_total_size(16'hFFFF);
        send_request(OP_ALLOC, 8'd5, 16'hFFFE);
        send_request(OP_ALLOC, 8'd6, 16'd1);
        send_request(OP_RELEASE, 8'd5, 16'd0);
        send_request(OP_RELEASE, 8'd6, 16'd0);
    endtask

    // Mostly allocate and release over a small set of jobs, so the table
    // fills, splits and coalesces; probes, reserved codes and full-range
    // fields are mixed in as noise.
    task automatic run_random(input int unsigned count, input logic [15:0] total);
        op_t         op;
        logic [7:0]  job;
        logic [15:0] req;
        int unsigned pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                op = OP_ALLOC;
            end else if (pick < 85) begin
                op = OP_RELEASE;
            end else if (pick < 96) begin
                op = OP_PROBE;
            end else begin
                op = OP_RSVD;
            end
            job = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(11));
            case ($urandom_range(9))
                0: req = 16'($urandom);
                1: req = 16'd0;
                2: req = total;
                default: req = 16'($urandom_range(1, (total >> 3) + 1));
            endcase
            send_request(op, job, req);
        end
    endtask

    // The receiver stalls for a long stretch while requests keep coming.
    task automatic test_backpressure();
        hold_off_cycles = 400;
        run_random(20, managed_size);
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        m_tready    = 1'b0;
        quiet_mode  = 1'b0;
        hold_off_cycles = 0;
        error_count = 0;
        response_count = 0;
        cycle_count = 0;
        clear_partitions(DEFAULT_TOTAL);
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_register_extremes();
        write_total_size(16'd640);
        run_random(400, 16'd640);
        test_backpressure();
        write_total_size(16'd64);
        run_random(300, 16'd64);
        quiet_mode = 1'b1;          // a long stretch with no idling at all
        run_random(250, 16'd64);
        quiet_mode = 1'b0;
        write_total_size(16'hFFFF);
        run_random(250, 16'hFFFF);
        write_total_size(16'd20);
        run_random(170, 16'd20);

        s_tvalid <= 1'b0;
        while (pending_responses.size() != 0) begin
            @(posedge aclk);
        end
        repeat (40) @(posedge aclk);

        $display("Covered %0d alloc, %0d release, %0d probe, %0d reserved requests, %0d responses",
                 op_seen[0], op_seen[1], op_seen[2], op_seen[3], response_count);
        $display("Responses: %0d ok, %0d no fit, %0d table full, %0d job not found",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/ffpa_pkg.sv
hw/rtl/ffpa_cell.sv
hw/rtl/first_fit_partition_allocator_core.sv
tb/sv/tb_top.sv
